// ===== rtl/pli_pkg.sv =====
// Shared types and codes for the positional list block.
package pli_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_PUSH   = 2'd2,
        CMD_POP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // Broadcast to every cell: hold, shift toward higher cells, shift toward cell 0.
    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_UP   = 2'd1,
        SH_DOWN = 2'd2
    } t_shift_op;

    typedef struct packed {
        t_cmd               command;
        logic signed [31:0] value;
        logic        [7:0]  position;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] popped_value;
        logic        [7:0]  list_length;
    } t_out_item;

endpackage

// ===== rtl/pli_cell.sv =====
// One list cell: holds one element and trades it with its neighbors.
module pli_cell #(
    parameter int ELEM_WIDTH = 32,
    parameter int IDX_W      = 7,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  pli_pkg::t_shift_op    i_op,
    input  logic [IDX_W-1:0]      i_key,
    input  logic [ELEM_WIDTH-1:0] i_value,
    input  logic [ELEM_WIDTH-1:0] i_left,
    input  logic [ELEM_WIDTH-1:0] i_right,
    output logic [ELEM_WIDTH-1:0] o_data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [ELEM_WIDTH-1:0] r_data;
    logic [ELEM_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_op)
            pli_pkg::SH_UP: begin
                // take the lower neighbor above the key, load the new value at it
                if (MY_IDX > i_key) begin
                    n_data = i_left;
                end else if (MY_IDX == i_key) begin
                    n_data = i_value;
                end
            end
            pli_pkg::SH_DOWN: begin
                if (MY_IDX >= i_key) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== rtl/positional_list_insert_erase.sv =====
// Top level of the positional list: command decode, length and a chain of element cells.
//
//  channel | valid      | stall       | payload                   | direction
//  --------+------------+-------------+---------------------------+----------
//  in      | i_in_valid | o_in_stall  | i_in_item  (t_in_item)    | into block
//  out     | o_out_valid| i_out_stall | o_out_item (t_out_item)   | out of block
//
// One command per cycle while the output is not stalled: every cell moves on
// the same clock edge that takes the command, which completes an insert, erase, push or pop.
// The result appears in the output register in the cycle after its transaction.
// The list is stored tail first: cell 0 holds the last element, so pop and
// push work at cell 0 and a list position p maps to cell (length-1-p).
// Reset clears the length and the output valid; cell contents are not reset.
// A stalled result holds the input side off only while it waits.
module positional_list_insert_erase #(
    parameter int CAPACITY   = 128,
    parameter int ELEM_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pli_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pli_pkg::t_out_item o_out_item
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CW > 8) ? CW : 8;

    // length and output register
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_out_valid;
    pli_pkg::t_out_item r_out_item;

    // decode
    logic                  w_in_acc;
    logic [CMP_W-1:0]      w_count_x;
    logic [CMP_W-1:0]      w_pos_x;
    logic [CMP_W-1:0]      w_ins_pos;
    logic [CMP_W-1:0]      w_len_x;
    pli_pkg::t_shift_op    w_op_raw;
    pli_pkg::t_shift_op    w_op;
    logic [IDX_W-1:0]      w_key;
    pli_pkg::t_status      w_status;
    logic [31:0]           w_popped;
    logic [31:0]           w_pop_ext;
    logic [ELEM_WIDTH-1:0] w_value;
    logic [ELEM_WIDTH-1:0] w_cell [CAPACITY];

    // stall input only while a finished result waits to be taken
    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_in_acc   = i_in_valid & ~o_in_stall;

    assign w_count_x = CMP_W'(r_count);
    assign w_pos_x   = CMP_W'(i_in_item.position);
    // push is an insert at the end of the list
    assign w_ins_pos = (i_in_item.command == pli_pkg::CMD_PUSH) ? w_count_x : w_pos_x;

    // fit the incoming 32-bit word to the element width, and the popped one back
    generate
        if (ELEM_WIDTH <= 32) begin : g_val_narrow
            assign w_value = i_in_item.value[ELEM_WIDTH-1:0];
        end else begin : g_val_wide
            assign w_value = {{(ELEM_WIDTH - 32){i_in_item.value[31]}}, i_in_item.value};
        end
        if (ELEM_WIDTH >= 32) begin : g_pop_wide
            assign w_pop_ext = w_cell[0][31:0];
        end else begin : g_pop_narrow
            assign w_pop_ext = {{(32 - ELEM_WIDTH){w_cell[0][ELEM_WIDTH-1]}}, w_cell[0]};
        end
    endgenerate

    always_comb begin
        w_op_raw = pli_pkg::SH_HOLD;
        w_key    = '0;
        w_status = pli_pkg::ST_OK;
        w_popped = '0;
        n_count  = r_count;
        case (i_in_item.command)
            pli_pkg::CMD_INSERT, pli_pkg::CMD_PUSH: begin
                if (w_ins_pos > w_count_x) begin
                    w_status = pli_pkg::ST_BADPOS;
                end else if (w_count_x >= CMP_W'(CAPACITY)) begin
                    w_status = pli_pkg::ST_FULL;
                end else begin
                    // cells above (length - pos) move up, that cell takes the value
                    w_op_raw = pli_pkg::SH_UP;
                    w_key    = IDX_W'(w_count_x - w_ins_pos);
                    n_count  = r_count + CW'(1);
                end
            end
            pli_pkg::CMD_ERASE: begin
                if (r_count == '0) begin
                    w_status = pli_pkg::ST_EMPTY;
                end else if (w_pos_x >= w_count_x) begin
                    w_status = pli_pkg::ST_BADPOS;
                end else begin
                    w_op_raw = pli_pkg::SH_DOWN;
                    w_key    = IDX_W'(w_count_x - w_pos_x - CMP_W'(1));
                    n_count  = r_count - CW'(1);
                end
            end
            pli_pkg::CMD_POP: begin
                if (r_count == '0) begin
                    w_status = pli_pkg::ST_EMPTY;
                end else begin
                    // the tail sits in cell 0: return it and advance the whole chain
                    w_op_raw = pli_pkg::SH_DOWN;
                    w_key    = '0;
                    w_popped = w_pop_ext;
                    n_count  = r_count - CW'(1);
                end
            end
            default: begin
                w_op_raw = pli_pkg::SH_HOLD;
            end
        endcase
    end

    // drop the shift unless the transaction is taken
    assign w_op    = w_in_acc ? w_op_raw : pli_pkg::SH_HOLD;
    assign w_len_x = CMP_W'(n_count);

    // chain of cells; the ends see zeros that are never kept in the list
    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            logic [ELEM_WIDTH-1:0] w_left;
            logic [ELEM_WIDTH-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_inner_l
                assign w_left = w_cell[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_inner_r
                assign w_right = w_cell[g+1];
            end
            pli_cell #(
                .ELEM_WIDTH (ELEM_WIDTH),
                .IDX_W      (IDX_W),
                .INDEX      (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op),
                .i_key   (w_key),
                .i_value (w_value),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_cell[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result until it is taken; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out_item.status       <= w_status;
            r_out_item.popped_value <= w_popped;
            r_out_item.list_length  <= w_len_x[7:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list length above capacity");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_out_valid)
        else $error("accepted command gave no result");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in_item.command == pli_pkg::CMD_PUSH && r_count != CW'(CAPACITY)
        |=> r_count == $past(r_count) + CW'(1))
        else $error("push below capacity did not grow the list");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in_item.command == pli_pkg::CMD_POP && r_count == '0
        |=> o_out_item.status == pli_pkg::ST_EMPTY && o_out_item.popped_value == '0)
        else $error("pop from empty list misreported");

endmodule
